### src/glbw_pkg.sv
// Package for the graphic LCD bus writer: item structs, command and phase
// codes, and fixed constants. No dependencies.
`default_nettype none

package glbw_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] STATUS_MASK       = 8'h90;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd16;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;
  localparam logic [7:0] MIN_LIMIT         = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_POLL_SETUP  = 3'd1,
    PH_POLL_HIGH   = 3'd2,
    PH_POLL_LOW    = 3'd3,
    PH_WRITE_SETUP = 3'd4,
    PH_WRITE_HIGH  = 3'd5,
    PH_WRITE_LOW   = 3'd6
  } phase_e;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic       mode;
    logic       chip;
    logic       is_data;
    logic [7:0] data_byte;
    logic [7:0] bus_in;
  } in_item_t;

  typedef struct packed {
    logic       chip_sel_one;
    logic       chip_sel_two;
    logic       enable_pin;
    logic       read_not_write;
    logic       data_not_instr;
    logic [7:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       chip;
    logic       is_data;
    logic [7:0] data_byte;
    logic [7:0] bus_in;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### src/glbw_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on glbw_pkg.
`default_nettype none

interface glbw_in_if;
  logic               valid;
  logic               ready;
  glbw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glbw_out_if;
  logic                valid;
  logic                ready;
  glbw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/graphic_lcd_bus_writer.sv
// Channel   Dir  Handshake          Payload
// in_i      in   valid/ready        mode, chip, is_data, data_byte, bus_in
// out_o     out  valid/ready        pin levels, ready_res, done_res
// cfg       in   cfg_we_i           cfg_wdata_i = phase_ticks
//
// One item per cycle unless out_o stalls; each goes via queue, output register.
// The two-entry command queue keeps in_i ready while out_o stalls, until full.
// Asynchronous active-low reset: idle, phase_ticks 16, queue and outputs empty.
// Top level of the graphic LCD bus writer; depends on glbw_pkg, glbw_if,
// glbw_front, glbw_queue and glbw_engine.
`default_nettype none

module graphic_lcd_bus_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  glbw_in_if.sink    in_i,
  glbw_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import glbw_pkg::*;

  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          pop_cmd;
  queue_status_t q_status;

  glbw_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  glbw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (q_status)
  );

  glbw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (pop_cmd),
    .empty_i     (q_status.empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.done_res |-> out_o.data.ready_res && !out_o.data.bus_drive)
    else $error("done without returning to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.bus_drive |-> !out_o.data.read_not_write)
    else $error("bus driven during status poll");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.chip_sel_one && out_o.data.chip_sel_two))
    else $error("both chip selects active");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full && !pop |=> !q_status.empty)
    else $error("queue lost commands while stalled");
`endif

endmodule

`default_nettype wire

### src/glbw_front.sv
// Front end: accepts input items and classifies them into tick or request
// commands for the queue. Depends on glbw_pkg and glbw_if.
`default_nettype none

module glbw_front (
  glbw_in_if.sink                 in_i,
  input  glbw_pkg::queue_status_t q_status_i,
  output logic                    push_o,
  output glbw_pkg::cmd_t          cmd_o
);
  import glbw_pkg::*;

  always_comb begin
    in_i.ready      = !q_status_i.full;
    push_o          = in_i.valid && !q_status_i.full;
    cmd_o.kind      = in_i.data.mode ? CMD_REQUEST : CMD_TICK;
    cmd_o.chip      = in_i.data.chip;
    cmd_o.is_data   = in_i.data.is_data;
    cmd_o.data_byte = in_i.data.data_byte;
    cmd_o.bus_in    = in_i.data.bus_in;
  end

endmodule

`default_nettype wire

### src/glbw_queue.sv
// Short command queue between front end and bus engine.
// Depends on glbw_pkg.
`default_nettype none

module glbw_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  glbw_pkg::cmd_t          push_cmd_i,
  input  logic                    pop_i,
  output glbw_pkg::cmd_t          pop_cmd_o,
  output glbw_pkg::queue_status_t status_o
);
  import glbw_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
    status_o.full  = (count_q == FullCnt);
    status_o.empty = (count_q == '0);
    pop_cmd_o      = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### src/glbw_engine.sv
// Bus engine: phase sequencer for status poll and write, phase_ticks
// register and the result output register. Depends on glbw_pkg and glbw_if.
`default_nettype none

module glbw_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  glbw_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  glbw_out_if.source     out_o
);
  import glbw_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic       chip_q, chip_d;
  logic       is_data_q, is_data_d;
  logic [7:0] byte_q, byte_d;
  logic       busy_q, busy_d;
  logic [7:0] ticks_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;

  logic [7:0] limit;
  logic [7:0] count_inc;
  logic       done;
  logic       polling;
  logic       writing;
  out_item_t  res;

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    chip_d    = chip_q;
    is_data_d = is_data_q;
    byte_d    = byte_q;
    busy_d    = busy_q;
    done      = 1'b0;
    limit     = (ticks_q == '0) ? MIN_LIMIT : ticks_q;
    count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;
    pop_o     = !empty_i && (!out_valid_q || out_o.ready);

    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_REQUEST: begin
          if (phase_q == PH_IDLE) begin
            chip_d    = cmd_i.chip;
            is_data_d = cmd_i.is_data;
            byte_d    = cmd_i.data_byte;
            busy_d    = 1'b1;
            count_d   = '0;
            phase_d   = PH_POLL_SETUP;
          end
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (count_inc < limit) begin
              count_d = count_inc;
            end else begin
              count_d = '0;
              unique case (phase_q)
                PH_POLL_SETUP:  phase_d = PH_POLL_HIGH;
                PH_POLL_HIGH: begin
                  busy_d  = |(cmd_i.bus_in & STATUS_MASK);
                  phase_d = PH_POLL_LOW;
                end
                PH_POLL_LOW:    phase_d = busy_q ? PH_POLL_SETUP : PH_WRITE_SETUP;
                PH_WRITE_SETUP: phase_d = PH_WRITE_HIGH;
                PH_WRITE_HIGH:  phase_d = PH_WRITE_LOW;
                PH_WRITE_LOW: begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
                default:        phase_d = PH_IDLE;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    polling = (phase_d == PH_POLL_SETUP) || (phase_d == PH_POLL_HIGH)
           || (phase_d == PH_POLL_LOW);
    writing = (phase_d == PH_WRITE_SETUP) || (phase_d == PH_WRITE_HIGH)
           || (phase_d == PH_WRITE_LOW);

    res.chip_sel_one   = (polling || writing) && !chip_d;
    res.chip_sel_two   = (polling || writing) && chip_d;
    res.enable_pin     = (phase_d == PH_POLL_HIGH) || (phase_d == PH_WRITE_HIGH);
    res.read_not_write = polling;
    res.data_not_instr = writing && is_data_d;
    res.bus_out        = writing ? byte_d : '0;
    res.bus_drive      = writing;
    res.ready_res      = !(polling || writing);
    res.done_res       = done;

    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
      out_data_d  = out_data_q;
    end

    out_o.valid = out_valid_q;
    out_o.data  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      chip_q      <= 1'b0;
      is_data_q   <= 1'b0;
      byte_q      <= '0;
      busy_q      <= 1'b1;
      ticks_q     <= PHASE_TICKS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      chip_q      <= chip_d;
      is_data_q   <= is_data_d;
      byte_q      <= byte_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for graphic_lcd_bus_writer: drives ticks and write requests,
// predicts the LCD pin levels of every item and compares each result in order.
// Depends on glbw_pkg, glbw_if and the graphic_lcd_bus_writer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import glbw_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_SLACK     = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int ITEMS_PER_SETTING = 140;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  glbw_in_if  in_ch ();
  glbw_out_if out_ch ();

  graphic_lcd_bus_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Expected pin levels, one per accepted item, oldest first.
  out_item_t pin_levels_q[$];

  // Predicted state of the bus sequencer.
  logic [7:0] phase_len;
  phase_e     lcd_phase;
  logic [7:0] tick_count;
  logic       held_chip;
  logic       held_is_data;
  logic [7:0] held_byte;
  logic       poll_busy;

  bit gaps_on;
  bit hold_off_req;
  int errors;
  int items_sent;
  int results_checked;
  int writes_done;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic out_item_t lcd_pins_after(in_item_t it);
    out_item_t  pins;
    logic [7:0] limit;
    logic       done;
    logic       polling;
    logic       writing;
    logic       active;
    done  = 1'b0;
    limit = (phase_len == 8'd0) ? 8'd1 : phase_len;
    if (it.mode == CMD_REQUEST) begin
      if (lcd_phase == PH_IDLE) begin
        held_chip    = it.chip;
        held_is_data = it.is_data;
        held_byte    = it.data_byte;
        poll_busy    = 1'b1;
        tick_count   = 8'd0;
        lcd_phase    = PH_POLL_SETUP;
      end
    end else if (lcd_phase != PH_IDLE) begin
      if (tick_count != 8'hFF) tick_count = tick_count + 8'd1;
      if (tick_count >= limit) begin
        tick_count = 8'd0;
        case (lcd_phase)
          PH_POLL_SETUP: lcd_phase = PH_POLL_HIGH;
          PH_POLL_HIGH: begin
            poll_busy = (it.bus_in & STATUS_MASK) != 8'd0;
            lcd_phase = PH_POLL_LOW;
          end
          PH_POLL_LOW: begin
            if (poll_busy) lcd_phase = PH_POLL_SETUP;
            else lcd_phase = PH_WRITE_SETUP;
          end
          PH_WRITE_SETUP: lcd_phase = PH_WRITE_HIGH;
          PH_WRITE_HIGH: lcd_phase = PH_WRITE_LOW;
          default: begin
            lcd_phase = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end
    polling = lcd_phase inside {PH_POLL_SETUP, PH_POLL_HIGH, PH_POLL_LOW};
    writing = lcd_phase inside {PH_WRITE_SETUP, PH_WRITE_HIGH, PH_WRITE_LOW};
    active  = polling || writing;
    pins.chip_sel_one   = active && !held_chip;
    pins.chip_sel_two   = active && held_chip;
    pins.enable_pin     = lcd_phase == PH_POLL_HIGH || lcd_phase == PH_WRITE_HIGH;
    pins.read_not_write = polling;
    pins.data_not_instr = writing && held_is_data;
    pins.bus_out        = writing ? held_byte : 8'd0;
    pins.bus_drive      = writing;
    pins.ready_res      = !active;
    pins.done_res       = done;
    return pins;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    pin_levels_q.push_back(lcd_pins_after(it));
    if (pin_levels_q[$].done_res) writes_done++;
    items_sent++;
  endtask

  task automatic send_tick(logic [7:0] bus);
    in_item_t it;
    it = '0;
    it.mode   = CMD_TICK;
    it.bus_in = bus;
    send_item(it);
  endtask

  task automatic send_request(logic chip, logic is_data, logic [7:0] byte_v);
    in_item_t it;
    it = '0;
    it.mode      = CMD_REQUEST;
    it.chip      = chip;
    it.is_data   = is_data;
    it.data_byte = byte_v;
    it.bus_in    = 8'($urandom);
    send_item(it);
  endtask

  task automatic run_to_idle();
    while (lcd_phase != PH_IDLE) send_tick(8'($urandom) & ~STATUS_MASK);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_phase_ticks(logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    phase_len = value;
  endtask

  // Mostly well-formed writes; some stray ticks while idle and requests while busy.
  function automatic in_item_t random_item();
    in_item_t it;
    it.chip      = 1'($urandom);
    it.is_data   = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.bus_in    = 8'($urandom);
    if ($urandom_range(0, 3) != 0) it.bus_in = it.bus_in & ~STATUS_MASK;
    if (lcd_phase == PH_IDLE) begin
      it.mode = ($urandom_range(0, 99) < 85) ? CMD_REQUEST : CMD_TICK;
    end else begin
      it.mode = ($urandom_range(0, 99) < 5) ? CMD_REQUEST : CMD_TICK;
    end
    return it;
  endfunction

  task automatic test_reset_length();
    send_request(1'b0, 1'b1, 8'hA5);
    repeat (18) send_tick(8'($urandom));
    write_phase_ticks(8'd0);
    run_to_idle();
  endtask

  task automatic test_status_polling();
    send_tick(8'hFF);
    send_request(1'b1, 1'b1, 8'hFF);
    send_request(1'b0, 1'b0, 8'h00);
    send_tick(8'h00);
    send_tick(8'h80);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h10);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h6F);
    repeat (4) send_tick(8'hFF);
    send_request(1'b0, 1'b0, 8'h00);
    repeat (6) send_tick(8'h00);
  endtask

  task automatic test_long_phase();
    write_phase_ticks(8'd255);
    send_request(1'b1, 1'b0, 8'h5A);
    repeat (260) send_tick(8'($urandom) & ~STATUS_MASK);
    write_phase_ticks(8'd1);
    run_to_idle();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) send_item(random_item());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] settings[7];
    in_item_t   it;
    int         counted;
    bit         effective;
    settings = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd4, 8'd3, 8'd1};
    for (int s = 0; s < 7; s++) begin
      write_phase_ticks(settings[s]);
      gaps_on = (s % 3) != 2;
      counted = 0;
      while (counted < ITEMS_PER_SETTING) begin
        it = random_item();
        effective = (it.mode == CMD_REQUEST) == (lcd_phase == PH_IDLE);
        send_item(it);
        if (effective) counted++;
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t exp_pins;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pin_levels_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        exp_pins = pin_levels_q.pop_front();
        check_field("chip_sel_one", exp_pins.chip_sel_one, out_ch.data.chip_sel_one);
        check_field("chip_sel_two", exp_pins.chip_sel_two, out_ch.data.chip_sel_two);
        check_field("enable_pin", exp_pins.enable_pin, out_ch.data.enable_pin);
        check_field("read_not_write", exp_pins.read_not_write, out_ch.data.read_not_write);
        check_field("data_not_instr", exp_pins.data_not_instr, out_ch.data.data_not_instr);
        check_field("bus_out", exp_pins.bus_out, out_ch.data.bus_out);
        check_field("bus_drive", exp_pins.bus_drive, out_ch.data.bus_drive);
        check_field("ready_res", exp_pins.ready_res, out_ch.data.ready_res);
        check_field("done_res", exp_pins.done_res, out_ch.data.done_res);
        results_checked++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        stall = idle_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 8'd0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    errors       = 0;
    phase_len    = PHASE_TICKS_RESET;
    lcd_phase    = PH_IDLE;
    tick_count   = 8'd0;
    held_chip    = 1'b0;
    held_is_data = 1'b0;
    held_byte    = 8'd0;
    poll_busy    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_length();
    test_status_polling();
    test_long_phase();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    $display("%0d items sent, %0d results checked, %0d LCD writes completed",
             items_sent, results_checked, writes_done);
    $display("phase lengths 0 to 255, busy and reset status polling, output hold-off");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
